### rtl/fct_pkg.sv
// Shared constants for the six-plane frustum cull test.
// No dependencies; used by the channel interfaces and the top level.
package fct_pkg;

  localparam int unsigned PLANE_COUNT     = 6;
  localparam int unsigned FRAC_BITS       = 14;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned WORD_W          = 16;
  localparam int unsigned AXES            = 3;
  localparam int unsigned KIND_W          = 2;
  localparam int unsigned RADIUS_W        = 15;
  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned COEF_WIDTH_DEF  = 16;

  // primitive kinds; the unused code is tested as a point
  localparam logic [KIND_W-1:0] KIND_POINT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BOX    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SPHERE = 2'd2;

endpackage

### rtl/fct_in_if.sv
// Input channel of the frustum cull test: one primitive per item.
// Depends on fct_pkg.
interface fct_in_if import fct_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic [KIND_W-1:0]             kind;
  logic signed [COORD_WIDTH-1:0] ax;
  logic signed [COORD_WIDTH-1:0] ay;
  logic signed [COORD_WIDTH-1:0] az;
  logic signed [COORD_WIDTH-1:0] bx;
  logic signed [COORD_WIDTH-1:0] by;
  logic signed [COORD_WIDTH-1:0] bz;
  logic [RADIUS_W-1:0]           radius;

  modport source (output valid, kind, ax, ay, az, bx, by, bz, radius, input ready);
  modport sink   (input valid, kind, ax, ay, az, bx, by, bz, radius, output ready);
endinterface

### rtl/fct_out_if.sv
// Output channel of the frustum cull test: one visibility flag per item.
// Depends on fct_pkg.
interface fct_out_if import fct_pkg::*;;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink   (input valid, visible, output ready);
endinterface

### rtl/frustum_cull_test_top.sv
// Six-plane view frustum cull test, four register stages.
// Depends on fct_pkg, fct_in_if and fct_out_if.
//
// Usage:
//   Planes are written through cfg_we_i / cfg_idx_i / cfg_data_i while no
//   item is in flight: index 0..5 selects a plane, packed as nx, ny, nz
//   (Q1.14) and d in 16-bit words from bit 0 upwards. Other indexes are ignored.
//   Each item on in_i (point, box or sphere) gives exactly one item on out_o
//   carrying visible.
//   Throughput: one item per clock cycle; the pipeline takes an item every
//   cycle as long as out_o is drained.
//   Path: the item passes the multiply, plane sum, compare and output registers
//   in that order; out_o carries the result from the output register.
//   Stall: when out_o.ready is low a full output register holds; earlier stages
//   keep filling their bubbles and in_i.ready drops only once every stage
//   holds an item. Nothing is dropped or repeated.
//   Reset: all planes read zero and the pipeline is empty. With zero planes
//   points and boxes are culled, spheres of nonzero radius are visible.
module frustum_cull_test_top import fct_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned COEF_WIDTH  = COEF_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  fct_in_if.sink                in_i,
  fct_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned KW     = COEF_WIDTH;
  localparam int unsigned PW     = CW + KW;
  localparam int unsigned BIG_W  = (CW > 15) ? CW : 15;
  localparam int unsigned SUM_W  = BIG_W + KW + 1;
  localparam int unsigned SW     = (SUM_W > RADIUS_W + FRAC_BITS + 1) ?
                                   SUM_W : RADIUS_W + FRAC_BITS + 2;

  // plane registers
  logic [CFG_DATA_W-1:0] plane_q [PLANE_COUNT];
  logic signed [KW-1:0]  coef_n [PLANE_COUNT][AXES];
  logic signed [KW-1:0]  coef_d [PLANE_COUNT];
  logic signed [SW-1:0]  dterm  [PLANE_COUNT];

  // stage valids and advance enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  // stage 1: products
  logic [KIND_W-1:0]     kind1_q;
  logic [RADIUS_W-1:0]   rad1_q;
  logic signed [PW-1:0]  pa_q [PLANE_COUNT][AXES];
  logic signed [PW-1:0]  pb_q [PLANE_COUNT][AXES];
  logic signed [CW-1:0]  ca [AXES];
  logic signed [CW-1:0]  cb [AXES];

  // stage 2: plane scores
  logic [KIND_W-1:0]     kind2_q;
  logic signed [SW-1:0]  rs2_q, rs2_d;
  logic signed [SW-1:0]  spt_q [PLANE_COUNT];
  logic signed [SW-1:0]  spt_d [PLANE_COUNT];
  logic signed [SW-1:0]  sbox_q [PLANE_COUNT];
  logic signed [SW-1:0]  sbox_d [PLANE_COUNT];

  // stage 3: per-plane flags
  logic [KIND_W-1:0]      kind3_q;
  logic [PLANE_COUNT-1:0] pt_out_q, pt_out_d;
  logic [PLANE_COUNT-1:0] box_out_q, box_out_d;
  logic [PLANE_COUNT-1:0] sph_cull_q, sph_cull_d;
  logic [PLANE_COUNT-1:0] sph_acc_q, sph_acc_d;

  // stage 4: output register
  logic vis_q, vis_d;

  assign en4 = !v4_q || out_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_i.ready    = en1;
  assign out_o.valid   = v4_q;
  assign out_o.visible = vis_q;

  // low COEF_WIDTH bits of each 16-bit word, signed
  for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_coef
    for (genvar a = 0; a < AXES; a++) begin : g_axis
      assign coef_n[p][a] = $signed(plane_q[p][a*WORD_W +: KW]);
    end
    assign coef_d[p] = $signed(plane_q[p][AXES*WORD_W +: KW]);
    assign dterm[p]  = SW'(coef_d[p]) <<< FRAC_BITS;
  end

  assign ca[0] = in_i.ax;
  assign ca[1] = in_i.ay;
  assign ca[2] = in_i.az;
  assign cb[0] = in_i.bx;
  assign cb[1] = in_i.by;
  assign cb[2] = in_i.bz;

  // stage 2 logic: the best box corner takes the larger product per axis
  always_comb begin
    logic signed [PW-1:0] mx;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      spt_d[p]  = dterm[p];
      sbox_d[p] = dterm[p];
      for (int a = 0; a < AXES; a++) begin
        mx        = (pa_q[p][a] > pb_q[p][a]) ? pa_q[p][a] : pb_q[p][a];
        spt_d[p]  = spt_d[p] + SW'(pa_q[p][a]);
        sbox_d[p] = sbox_d[p] + SW'(mx);
      end
    end
    rs2_d = $signed(SW'({rad1_q, FRAC_BITS'(0)}));
  end

  // stage 3 logic
  always_comb begin
    logic signed [SW-1:0] neg_rs;
    logic signed [SW-1:0] mag;
    neg_rs = -rs2_q;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      mag           = (spt_q[p] < 0) ? -spt_q[p] : spt_q[p];
      pt_out_d[p]   = (spt_q[p] <= 0);
      box_out_d[p]  = (sbox_q[p] <= 0);
      sph_cull_d[p] = (spt_q[p] < neg_rs);
      sph_acc_d[p]  = (mag < rs2_q);
    end
  end

  // stage 4 logic: the sphere stops at the first plane that decides it
  always_comb begin
    logic sph_vis;
    sph_vis = 1'b1;
    for (int p = PLANE_COUNT - 1; p >= 0; p--) begin
      if (sph_cull_q[p]) begin
        sph_vis = 1'b0;
      end else if (sph_acc_q[p]) begin
        sph_vis = 1'b1;
      end
    end
    case (kind3_q)
      KIND_BOX:    vis_d = ~|box_out_q;
      KIND_SPHERE: vis_d = sph_vis;
      default:     vis_d = ~|pt_out_q;
    endcase
  end

  // control state and planes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      for (int p = 0; p < PLANE_COUNT; p++) begin
        plane_q[p] <= '0;
      end
    end else begin
      if (en1) begin
        v1_q <= in_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
      if (cfg_we_i && (32'(cfg_idx_i) < PLANE_COUNT)) begin
        plane_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (en1) begin
      kind1_q <= in_i.kind;
      rad1_q  <= in_i.radius;
      for (int p = 0; p < PLANE_COUNT; p++) begin
        for (int a = 0; a < AXES; a++) begin
          pa_q[p][a] <= PW'(coef_n[p][a]) * PW'(ca[a]);
          pb_q[p][a] <= PW'(coef_n[p][a]) * PW'(cb[a]);
        end
      end
    end
    if (en2) begin
      kind2_q <= kind1_q;
      rs2_q   <= rs2_d;
      spt_q   <= spt_d;
      sbox_q  <= sbox_d;
    end
    if (en3) begin
      kind3_q    <= kind2_q;
      pt_out_q   <= pt_out_d;
      box_out_q  <= box_out_d;
      sph_cull_q <= sph_cull_d;
      sph_acc_q  <= sph_acc_d;
    end
    if (en4) begin
      vis_q <= vis_d;
    end
  end

  // a sphere can never be both rejected and accepted by one plane
  a_sph_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> !(|(sph_cull_q & sph_acc_q)))
    else $error("sphere plane both culled and accepted");

  // a point outside any plane leaves the pipeline culled
  a_pt_cull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en4 && kind3_q != KIND_BOX && kind3_q != KIND_SPHERE && (|pt_out_q))
    |=> (v4_q && !vis_q))
    else $error("culled point reported visible");

  // an accepted item always lands in the first stage
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v1_q)
    else $error("accepted item lost at entry");

  // a held stage 2 keeps its plane 0 scores
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !en3) |=> (v2_q && $stable(spt_q[0]) && $stable(sbox_q[0])))
    else $error("stalled stage changed");

endmodule
